FILE: rtl/awmc_pkg.sv
// ----------------------------------------------------------------------------
// awmc_pkg: shared types and constants for the mesh centroid core
// Field widths, queue entry layout and division/sqrt sizes.
// ----------------------------------------------------------------------------
package awmc_pkg;

    localparam int COORD_BITS = 16;
    localparam int SUM_BITS   = 64;
    localparam int WGT_BITS   = 48;
    localparam int SQ_BITS    = 82;
    localparam int ROOT_BITS  = 41;
    localparam int VSUM_BITS  = COORD_BITS + 2;
    localparam int DIV_BITS   = WGT_BITS + 2;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = 2;

    typedef struct packed {
        logic signed [VSUM_BITS-1:0] sx;
        logic signed [VSUM_BITS-1:0] sy;
        logic signed [VSUM_BITS-1:0] sz;
        logic [SQ_BITS-1:0]          sq;
        logic                        last;
    } tri_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic                         degen;
        logic                         sat;
    } res_t;

endpackage

FILE: rtl/awmc_front.sv
// ----------------------------------------------------------------------------
// awmc_front: triangle front end
// Pipelined edges, cross product, squared norm and vertex sums, one item
// per cycle; stalls as a whole when the output stage is held.
// ----------------------------------------------------------------------------
module awmc_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [awmc_pkg::COORD_BITS-1:0] ax, ay, az, bx, by_c, bz, cx, cy, cz,
    input  logic                              last_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output awmc_pkg::tri_t                    out_tri
);
    localparam int EB = awmc_pkg::COORD_BITS + 1;
    localparam int NB = 2 * EB + 1;
    localparam int PB = 2 * NB;

    logic [2:0] vld_reg;
    logic       adv;
    assign adv      = !vld_reg[2] || out_ready;
    assign in_ready = adv;

    logic signed [EB-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [awmc_pkg::VSUM_BITS-1:0] s0x_reg, s0y_reg, s0z_reg;
    logic s0l_reg;
    logic signed [NB-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [awmc_pkg::VSUM_BITS-1:0] s1x_reg, s1y_reg, s1z_reg;
    logic s1l_reg;
    awmc_pkg::tri_t t2_reg;

    logic [NB-1:0] mx, my, mz;
    assign mx = nx_reg[NB-1] ? NB'(-nx_reg) : NB'(nx_reg);
    assign my = ny_reg[NB-1] ? NB'(-ny_reg) : NB'(ny_reg);
    assign mz = nz_reg[NB-1] ? NB'(-nz_reg) : NB'(nz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
        if (adv) begin
            ux_reg  <= EB'(bx) - EB'(ax);
            uy_reg  <= EB'(by_c) - EB'(ay);
            uz_reg  <= EB'(bz) - EB'(az);
            vx_reg  <= EB'(cx) - EB'(ax);
            vy_reg  <= EB'(cy) - EB'(ay);
            vz_reg  <= EB'(cz) - EB'(az);
            s0x_reg <= awmc_pkg::VSUM_BITS'(ax) + awmc_pkg::VSUM_BITS'(bx)
                       + awmc_pkg::VSUM_BITS'(cx);
            s0y_reg <= awmc_pkg::VSUM_BITS'(ay) + awmc_pkg::VSUM_BITS'(by_c)
                       + awmc_pkg::VSUM_BITS'(cy);
            s0z_reg <= awmc_pkg::VSUM_BITS'(az) + awmc_pkg::VSUM_BITS'(bz)
                       + awmc_pkg::VSUM_BITS'(cz);
            s0l_reg <= last_in;
            nx_reg  <= NB'(uy_reg * vz_reg) - NB'(uz_reg * vy_reg);
            ny_reg  <= NB'(uz_reg * vx_reg) - NB'(ux_reg * vz_reg);
            nz_reg  <= NB'(ux_reg * vy_reg) - NB'(uy_reg * vx_reg);
            s1x_reg <= s0x_reg;
            s1y_reg <= s0y_reg;
            s1z_reg <= s0z_reg;
            s1l_reg <= s0l_reg;
            t2_reg.sq   <= awmc_pkg::SQ_BITS'(PB'(mx) * PB'(mx))
                         + awmc_pkg::SQ_BITS'(PB'(my) * PB'(my))
                         + awmc_pkg::SQ_BITS'(PB'(mz) * PB'(mz));
            t2_reg.sx   <= s1x_reg;
            t2_reg.sy   <= s1y_reg;
            t2_reg.sz   <= s1z_reg;
            t2_reg.last <= s1l_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_tri   = t2_reg;

endmodule

FILE: rtl/awmc_fifo.sv
// ----------------------------------------------------------------------------
// awmc_fifo: small queue between front and back
// Holds front-end triangle items so each side stalls on its own.
// ----------------------------------------------------------------------------
module awmc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  awmc_pkg::tri_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output awmc_pkg::tri_t rd_data
);
    awmc_pkg::tri_t mem [awmc_pkg::QDEPTH];
    logic [awmc_pkg::QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [awmc_pkg::QPTR_BITS:0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != (awmc_pkg::QPTR_BITS+1)'(awmc_pkg::QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            if (wr && !rd) cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr) cnt_reg <= cnt_reg - 1'b1;
        end
        if (wr) mem[wp_reg] <= wr_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (awmc_pkg::QPTR_BITS+1)'(awmc_pkg::QDEPTH))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wp_reg == rp_reg))
        else $error("empty queue pointers differ");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a write");

endmodule

FILE: rtl/awmc_back.sv
// ----------------------------------------------------------------------------
// awmc_back: accumulate and divide engine
// Bit-serial square root, 24x18 partial-product weighting, saturating
// accumulation, and on the last item a restoring divide per axis.
// ----------------------------------------------------------------------------
module awmc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  awmc_pkg::tri_t in_tri,
    output logic           res_valid,
    input  logic           res_ready,
    output awmc_pkg::res_t res
);
    localparam int SB = awmc_pkg::SUM_BITS;
    localparam int WB = awmc_pkg::WGT_BITS;
    localparam int RB = awmc_pkg::ROOT_BITS;
    localparam int QB = awmc_pkg::SQ_BITS;
    localparam int VB = awmc_pkg::VSUM_BITS;
    localparam int DB = awmc_pkg::DIV_BITS;
    localparam int CB = awmc_pkg::COORD_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQRT = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_ACC  = 4'd3;
    localparam logic [3:0] ST_DSET = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_DFIN = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    logic [3:0] st_reg;
    logic [5:0] bit_reg;
    logic [1:0] ax_reg;
    logic       ph_reg;

    awmc_pkg::tri_t t_reg;
    logic [RB-1:0] root_reg;
    logic [QB-1:0] rad_reg;
    logic [RB:0]   rem_reg;
    logic signed [SB-1:0] sumx_reg, sumy_reg, sumz_reg;
    logic [WB-1:0] tw_reg;
    logic ovf_reg;
    logic signed [SB-1:0] px_reg, py_reg, pz_reg;
    logic [SB-1:0] mag_reg;
    logic neg_reg;
    logic [DB-1:0] div_reg;
    logic [SB-1:0] q_reg;
    logic [DB:0] r_reg;
    logic signed [CB-1:0] cx_reg, cy_reg, cz_reg;
    logic degen_reg;
    logic ovf_out_reg;
    logic out_v_reg;

    assign in_ready  = st_reg == ST_IDLE;
    assign res_valid = out_v_reg;
    assign res.cx    = cx_reg;
    assign res.cy    = cy_reg;
    assign res.cz    = cz_reg;
    assign res.degen = degen_reg;
    assign res.sat   = ovf_out_reg;

    // square root step: bring down two bits, try (root << 2) | 1
    logic [RB+2:0] sq_rem, sq_try;
    assign sq_rem = {rem_reg, rad_reg[QB-1:QB-2]};
    assign sq_try = {1'b0, root_reg, 2'b01};

    // weight times vertex sum, 2 partial products of 24x18 bits
    logic signed [VB-1:0] vs;
    always_comb begin
        case (ax_reg)
            2'd0:    vs = t_reg.sx;
            2'd1:    vs = t_reg.sy;
            default: vs = t_reg.sz;
        endcase
    end
    logic [23:0] wpart;
    assign wpart = ph_reg ? 24'(root_reg[RB-1:24]) : root_reg[23:0];
    logic signed [SB-1:0] pp;
    assign pp = SB'($signed({1'b0, wpart}) * vs);

    // saturating add
    function automatic logic [SB:0] sadd(input logic signed [SB-1:0] a,
                                         input logic signed [SB-1:0] b);
        logic signed [SB-1:0] s;
        logic o;
        s = a + b;
        o = (a[SB-1] == b[SB-1]) && (s[SB-1] != a[SB-1]);
        if (o) s = a[SB-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        return {o, s};
    endfunction

    logic [SB:0] rx, ry, rz;
    assign rx = sadd(sumx_reg, px_reg);
    assign ry = sadd(sumy_reg, py_reg);
    assign rz = sadd(sumz_reg, pz_reg);
    logic [WB:0] tws;
    assign tws = (WB+1)'(tw_reg) + (WB+1)'(root_reg);

    logic signed [SB-1:0] dsum;
    always_comb begin
        case (ax_reg)
            2'd0:    dsum = sumx_reg;
            2'd1:    dsum = sumy_reg;
            default: dsum = sumz_reg;
        endcase
    end

    logic [DB:0] rtry;
    assign rtry = {r_reg[DB-1:0], mag_reg[SB-1]};
    logic signed [CB-1:0] cres;
    always_comb begin
        if (neg_reg) begin
            if (q_reg > SB'(1) << (CB-1)) cres = {1'b1, {(CB-1){1'b0}}};
            else cres = CB'(-q_reg);
        end else begin
            if (q_reg > (SB'(1) << (CB-1)) - SB'(1)) cres = {1'b0, {(CB-1){1'b1}}};
            else cres = CB'(q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            out_v_reg <= 1'b0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
            sumz_reg  <= '0;
            tw_reg    <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (out_v_reg && res_ready) out_v_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        t_reg    <= in_tri;
                        root_reg <= '0;
                        rem_reg  <= '0;
                        rad_reg  <= in_tri.sq;
                        bit_reg  <= 6'(RB - 1);
                        st_reg   <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_rem >= sq_try) begin
                        rem_reg  <= (RB+1)'(sq_rem - sq_try);
                        root_reg <= {root_reg[RB-2:0], 1'b1};
                    end else begin
                        rem_reg  <= sq_rem[RB:0];
                        root_reg <= {root_reg[RB-2:0], 1'b0};
                    end
                    rad_reg <= {rad_reg[QB-3:0], 2'b00};
                    if (bit_reg == '0) begin
                        ax_reg <= 2'd0;
                        ph_reg <= 1'b0;
                        st_reg <= ST_MUL;
                    end
                    bit_reg <= bit_reg - 1'b1;
                end
                ST_MUL: begin
                    logic signed [SB-1:0] acc;
                    acc = ph_reg ? (pp <<< 24) : pp;
                    case (ax_reg)
                        2'd0:    px_reg <= ph_reg ? px_reg + acc : acc;
                        2'd1:    py_reg <= ph_reg ? py_reg + acc : acc;
                        default: pz_reg <= ph_reg ? pz_reg + acc : acc;
                    endcase
                    if (ph_reg) begin
                        ph_reg <= 1'b0;
                        if (ax_reg == 2'd2) st_reg <= ST_ACC;
                        ax_reg <= ax_reg + 1'b1;
                    end else begin
                        ph_reg <= 1'b1;
                    end
                end
                ST_ACC: begin
                    logic ov;
                    ov = rx[SB] | ry[SB] | rz[SB] | tws[WB];
                    sumx_reg <= rx[SB-1:0];
                    sumy_reg <= ry[SB-1:0];
                    sumz_reg <= rz[SB-1:0];
                    tw_reg   <= tws[WB] ? {WB{1'b1}} : tws[WB-1:0];
                    if (ov) ovf_reg <= 1'b1;
                    if (!t_reg.last) begin
                        st_reg <= ST_IDLE;
                    end else begin
                        ax_reg <= 2'd0;
                        st_reg <= ST_DSET;
                    end
                end
                ST_DSET: begin
                    // result registers stay untouched until the pending item is taken
                    if (ax_reg != 2'd0 || !out_v_reg) begin
                        if (ax_reg == 2'd0) begin
                            ovf_out_reg <= ovf_reg;
                            degen_reg   <= tw_reg == '0;
                            div_reg     <= DB'(tw_reg) + DB'({tw_reg, 1'b0});
                        end
                        if (ax_reg == 2'd0 && tw_reg == '0) begin
                            cx_reg <= '0;
                            cy_reg <= '0;
                            cz_reg <= '0;
                            st_reg <= ST_OUT;
                        end else begin
                            neg_reg <= dsum[SB-1];
                            mag_reg <= dsum[SB-1] ? SB'(-dsum) : SB'(dsum);
                            q_reg   <= '0;
                            r_reg   <= '0;
                            bit_reg <= 6'(SB - 1);
                            st_reg  <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (rtry >= (DB+1)'(div_reg)) begin
                        r_reg <= rtry - (DB+1)'(div_reg);
                        q_reg <= {q_reg[SB-2:0], 1'b1};
                    end else begin
                        r_reg <= rtry;
                        q_reg <= {q_reg[SB-2:0], 1'b0};
                    end
                    mag_reg <= {mag_reg[SB-2:0], 1'b0};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) st_reg <= ST_DFIN;
                end
                ST_DFIN: begin
                    case (ax_reg)
                        2'd0:    cx_reg <= cres;
                        2'd1:    cy_reg <= cres;
                        default: cz_reg <= cres;
                    endcase
                    ax_reg <= ax_reg + 1'b1;
                    st_reg <= (ax_reg == 2'd2) ? ST_OUT : ST_DSET;
                end
                ST_OUT: begin
                    if (!out_v_reg) begin
                        out_v_reg <= 1'b1;
                        sumx_reg  <= '0;
                        sumy_reg  <= '0;
                        sumz_reg  <= '0;
                        tw_reg    <= '0;
                        ovf_reg   <= 1'b0;
                        st_reg    <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT && !out_v_reg) |=> out_v_reg)
        else $error("result not posted");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && !res_ready) |=> (out_v_reg && $stable(cx_reg)))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_v_reg && degen_reg) |-> (cx_reg == '0 && cy_reg == '0 && cz_reg == '0))
        else $error("degenerate result not zero");

endmodule

FILE: rtl/area_weighted_mesh_centroid_core.sv
// ----------------------------------------------------------------------------
// area_weighted_mesh_centroid_core: area-weighted triangle mesh centroid
// Streams triangles in, emits one centroid per mesh.
// ----------------------------------------------------------------------------
// Input channel s_*: one triangle per item (three signed vertices and
// s_last_triangle). Result channel m_*: one item per mesh, after the item
// marked last, with the centroid, a degenerate flag for zero total area and
// a saturation flag.
// The front pipeline takes one item per cycle into a four-entry queue,
// stalling when its output stage is held by a full queue. The back
// engine takes one triangle at a time from the queue and runs a 41-step
// bit-serial square root for the weight, six partial-product steps and
// an accumulate. The last triangle adds three 64-step restoring divides
// with their setup. No new triangle is taken until the last is done, so
// sustained throughput is set by the square root iteration.
// Reset (aresetn low, synchronous) clears the sums, the queue and any
// pending result. A stalled m_ready holds the result; the back engine keeps
// accumulating but waits for it before starting the next divide, while the
// front keeps filling the queue.
// ----------------------------------------------------------------------------
module area_weighted_mesh_centroid_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [15:0] s_ax,
    input  logic signed [15:0] s_ay,
    input  logic signed [15:0] s_az,
    input  logic signed [15:0] s_bx,
    input  logic signed [15:0] s_by_coord,
    input  logic signed [15:0] s_bz,
    input  logic signed [15:0] s_cx,
    input  logic signed [15:0] s_cy,
    input  logic signed [15:0] s_cz,
    input  logic        s_last_triangle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_center_x,
    output logic signed [15:0] m_center_y,
    output logic signed [15:0] m_center_z,
    output logic        m_degenerate,
    output logic        m_saturated
);
    logic f_valid, f_ready, q_valid, q_ready;
    awmc_pkg::tri_t f_tri, q_tri;
    awmc_pkg::res_t res;

    awmc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .ax(s_ax), .ay(s_ay), .az(s_az),
        .bx(s_bx), .by_c(s_by_coord), .bz(s_bz),
        .cx(s_cx), .cy(s_cy), .cz(s_cz),
        .last_in(s_last_triangle),
        .out_valid(f_valid), .out_ready(f_ready), .out_tri(f_tri)
    );

    awmc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tri),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tri)
    );

    awmc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_tri(q_tri),
        .res_valid(m_valid), .res_ready(m_ready), .res(res)
    );

    assign m_center_x   = res.cx;
    assign m_center_y   = res.cy;
    assign m_center_z   = res.cz;
    assign m_degenerate = res.degen;
    assign m_saturated  = res.sat;

endmodule
